@@ hdl/kelm_pkg.sv @@
// kelm_pkg: shared types and constants for the key event listener match unit.
// Used by kelm_cell and key_event_listener_match_unit. No dependencies.
`default_nettype none

package kelm_pkg;

  // Table geometry
  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Listener flag bit positions
  localparam int FL_PRESSED   = 0;
  localparam int FL_RELEASED  = 1;
  localparam int FL_KEYCODE   = 2;
  localparam int FL_CHARACTER = 3;
  localparam int BREAK_BIT    = 7;

  // One table entry; client sits in the low bits
  typedef struct packed {
    logic [7:0]  modifier;
    logic [7:0]  key;
    logic [7:0]  flags;
    logic [15:0] client;
  } entry_t;

  // Input transaction kinds
  typedef enum logic [1:0] {
    FN_EVENT  = 2'd0,
    FN_ADD    = 2'd1,
    FN_REMOVE = 2'd2
  } func_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EXISTS   = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_NOMATCH  = 3'd4
  } status_t;

  // Operation applied to the whole row of cells at once
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_APPEND = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [CNT_W-1:0] cnt;
    entry_t           ent;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/kelm_cell.sv @@
// kelm_cell: one slot of the listener table. Holds one entry, compares it,
// and takes data from its right neighbor on remove and rotate. Uses kelm_pkg.
`default_nettype none

module kelm_cell (
  input  wire logic                     clk,
  input  wire kelm_pkg::cell_ctrl_t     ctrl,
  input  wire logic [kelm_pkg::IDX_W-1:0] idx,
  input  wire kelm_pkg::entry_t         right_in,
  input  wire kelm_pkg::entry_t         head_in,
  input  wire logic                     seen_in,
  output logic                          seen_out,
  output kelm_pkg::entry_t              entry_out
);
  import kelm_pkg::*;

  entry_t           entry_r;
  entry_t           entry_nxt;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] pos_p1;
  logic             in_use;
  logic             hit;

  assign pos    = CNT_W'(idx);
  assign pos_p1 = pos + CNT_W'(1);
  assign in_use = pos < ctrl.cnt;
  assign hit    = in_use && (entry_r == ctrl.ent);

  // Exact-match chain: high from the first matching slot onward
  assign seen_out  = seen_in | hit;
  assign entry_out = entry_r;

  // Next entry per row operation
  always_comb begin
    entry_nxt = entry_r;
    case (ctrl.op)
      CELL_APPEND: begin
        if (pos == ctrl.cnt) entry_nxt = ctrl.ent;
      end
      CELL_REMOVE: begin
        if (seen_out) entry_nxt = right_in;
      end
      CELL_ROTATE: begin
        if (pos_p1 < ctrl.cnt) entry_nxt = right_in;
        else if (pos_p1 == ctrl.cnt) entry_nxt = head_in;
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

@@ hdl/key_event_listener_match_unit.sv @@
// Key event listener match unit: ordered listener table with event matching.
// Uses kelm_pkg and a row of kelm_cell slots.
//
// Input channel in_*: in_tuser selects the transaction kind (key event, add
// listener, remove listener); in_tdata carries the listener or event fields.
// Output channel out_*: one transaction per result, out_tlast on the final one.
// Add and remove finish when taken: all slots compare against the new
// entry at once and the result lands in the output register at the accepting edge.
// Remove closes the gap by shifting later slots one place left.
// A key event rotates the table through slot 0 once, one slot per cycle, and
// checks each listener as it passes. Its final result is registered when the
// rotation is done and the output register is free; the next transaction is
// taken once idle again when the receiver keeps up. Results pass through one
// held-back register so the final one can carry tlast; a stalled receiver
// pauses the rotation when a second hit has nowhere to go.
// A new transaction is taken only when idle and the output register is free:
// one add or remove per cycle at best.
// Reset (rst_n low, synchronous) empties the table and drops any pending
// result; the table storage itself is not cleared.
// A transaction of an unused kind is accepted and gives no result.
`default_nettype none

module key_event_listener_match_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: client[15:0], listen_flags[23:16], listen_key[31:24],
  //           modifier[39:32], keycode[47:40], character[55:48]
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,
  // in_tuser: func[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_tdata: client_res[15:0]
  output logic [15:0]      out_tdata,
  // out_tuser: status[2:0]
  output logic [2:0]       out_tuser,
  output logic             out_tlast
);
  import kelm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic [7:0]       ev_mod_r, ev_mod_nxt;
  logic [7:0]       ev_kc_r, ev_kc_nxt;
  logic [7:0]       ev_ch_r, ev_ch_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  logic [15:0]      pend_client_r, pend_client_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [15:0]      out_client_r, out_client_nxt;
  status_t          out_status_r, out_status_nxt;
  logic             out_last_r, out_last_nxt;

  cell_ctrl_t       ctrl;
  entry_t           new_ent;
  entry_t           entry_w [DEPTH];
  logic             seen_w [DEPTH+1];
  entry_t           head;
  logic             found;
  logic             out_free;
  logic             in_acc;
  logic             brk;
  logic             dir_ok;
  logic             key_ok;
  logic             head_hit;

  assign new_ent.client   = in_tdata[15:0];
  assign new_ent.flags    = in_tdata[23:16];
  assign new_ent.key      = in_tdata[31:24];
  assign new_ent.modifier = in_tdata[39:32];

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;

  // Row of table slots
  assign seen_w[0] = 1'b0;
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t right;
    if (i == DEPTH - 1) begin : g_end
      assign right = entry_w[i];
    end else begin : g_mid
      assign right = entry_w[i+1];
    end
    kelm_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .idx      (IDX_W'(i)),
      .right_in (right),
      .head_in  (entry_w[0]),
      .seen_in  (seen_w[i]),
      .seen_out (seen_w[i+1]),
      .entry_out(entry_w[i])
    );
  end
  assign found = seen_w[DEPTH];

  // Event match for the listener currently in slot 0
  assign head   = entry_w[0];
  assign brk    = ev_mod_r[BREAK_BIT];
  assign dir_ok = (head.flags[FL_RELEASED] && brk) || (head.flags[FL_PRESSED] && !brk);
  assign key_ok = (head.flags[FL_KEYCODE] && (head.key == ev_kc_r)) ||
                  (head.flags[FL_CHARACTER] && (head.key == ev_ch_r));
  assign head_hit = (head.modifier == ev_mod_r) && dir_ok && key_ok;

  // Control: accept, table update, scan and result registers
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    scan_nxt        = scan_r;
    ev_mod_nxt      = ev_mod_r;
    ev_kc_nxt       = ev_kc_r;
    ev_ch_nxt       = ev_ch_r;
    pend_valid_nxt  = pend_valid_r;
    pend_client_nxt = pend_client_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_client_nxt  = out_client_r;
    out_status_nxt  = out_status_r;
    out_last_nxt    = out_last_r;
    ctrl.op         = CELL_HOLD;
    ctrl.cnt        = count_r;
    ctrl.ent        = new_ent;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (func_t'(in_tuser))
            FN_EVENT: begin
              ev_mod_nxt     = in_tdata[39:32];
              ev_kc_nxt      = in_tdata[47:40];
              ev_ch_nxt      = in_tdata[55:48];
              scan_nxt       = '0;
              pend_valid_nxt = 1'b0;
              state_nxt      = S_SCAN;
            end
            FN_ADD: begin
              out_valid_nxt  = 1'b1;
              out_client_nxt = '0;
              out_last_nxt   = 1'b1;
              if (found) begin
                out_status_nxt = ST_EXISTS;
              end else if (count_r == CNT_W'(DEPTH)) begin
                out_status_nxt = ST_FULL;
              end else begin
                ctrl.op        = CELL_APPEND;
                count_nxt      = count_r + CNT_W'(1);
                out_status_nxt = ST_OK;
              end
            end
            FN_REMOVE: begin
              out_valid_nxt  = 1'b1;
              out_client_nxt = '0;
              out_last_nxt   = 1'b1;
              if (found) begin
                ctrl.op        = CELL_REMOVE;
                count_nxt      = count_r - CNT_W'(1);
                out_status_nxt = ST_OK;
              end else begin
                out_status_nxt = ST_NOTFOUND;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_r != count_r) begin
          // Step one slot unless a held result has nowhere to go
          if (!(head_hit && pend_valid_r && !out_free)) begin
            ctrl.op  = CELL_ROTATE;
            scan_nxt = scan_r + CNT_W'(1);
            if (head_hit) begin
              if (pend_valid_r) begin
                out_valid_nxt  = 1'b1;
                out_client_nxt = pend_client_r;
                out_status_nxt = ST_OK;
                out_last_nxt   = 1'b0;
              end
              pend_valid_nxt  = 1'b1;
              pend_client_nxt = head.client;
            end
          end
        end else if (out_free) begin
          // Final result of the event
          out_valid_nxt  = 1'b1;
          out_last_nxt   = 1'b1;
          out_client_nxt = pend_valid_r ? pend_client_r : 16'd0;
          out_status_nxt = pend_valid_r ? ST_OK : ST_NOMATCH;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      scan_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      scan_r       <= scan_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ev_mod_r      <= ev_mod_nxt;
    ev_kc_r       <= ev_kc_nxt;
    ev_ch_r       <= ev_ch_nxt;
    pend_client_r <= pend_client_nxt;
    out_client_r  <= out_client_nxt;
    out_status_r  <= out_status_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_client_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

@@ tb/key_event_listener_match_unit_tb.sv @@
// Testbench for key_event_listener_match_unit: drives listener adds, removes and key
// events, tracks the listener table in a local model and checks every result transaction.
// Depends on kelm_pkg and the key_event_listener_match_unit RTL.
`default_nettype none

module key_event_listener_match_unit_tb;
  import kelm_pkg::*;

  // Selector value the block does not use
  localparam logic [1:0] FN_SPARE = 2'd3;

  // Flag masks built from the package bit positions
  localparam logic [7:0] F_PRESS   = 8'(1 << FL_PRESSED);
  localparam logic [7:0] F_CODE    = 8'(1 << FL_KEYCODE);
  localparam logic [7:0] F_CHAR    = 8'(1 << FL_CHARACTER);

  // Longest quiet stretch of a good run: the receiver hold-off plus a full-table
  // scan, a receiver stall burst and a sender gap; taken several times over.
  localparam int QUIET_LIMIT = 1000;
  localparam int TAIL_CYCLES = 2 * DEPTH + 8;
  localparam int HOLD_CYCLES = 150;

  typedef struct packed {
    logic [15:0] client;
    status_t     status;
    logic        last;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  // Local copy of the listener table, in insertion order
  entry_t listeners[$];
  // Result transactions the block still owes, oldest first
  reply_t owed_replies[$];

  int fail_count = 0;
  int quiet_cycles = 0;
  int hold_off_cycles = 0;
  bit src_gaps = 1'b1;
  bit sink_stalls = 1'b1;

  key_event_listener_match_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Table model
  // ---------------------------------------------------------------------------

  function automatic void owe(logic [15:0] client, status_t status, logic last);
    reply_t r;
    r.client = client;
    r.status = status;
    r.last   = last;
    owed_replies.push_back(r);
  endfunction

  function automatic int find_listener(entry_t e);
    for (int i = 0; i < listeners.size(); i++) begin
      if (listeners[i] == e) return i;
    end
    return -1;
  endfunction

  // Modifier must match in full; direction flag must agree with the break bit
  function automatic bit listener_fires(entry_t x, logic [7:0] mod, logic [7:0] kc,
                                        logic [7:0] ch);
    bit brk;
    bit dir;
    bit key_ok;
    brk    = mod[BREAK_BIT];
    dir    = (x.flags[FL_RELEASED] && brk) || (x.flags[FL_PRESSED] && !brk);
    key_ok = (x.flags[FL_KEYCODE] && x.key == kc) || (x.flags[FL_CHARACTER] && x.key == ch);
    return (x.modifier == mod) && dir && key_ok;
  endfunction

  // Apply one accepted transaction to the model and queue the results it owes
  function automatic void apply_to_table(logic [1:0] fn, entry_t ent, logic [7:0] kc,
                                         logic [7:0] ch);
    int pos;
    int last_hit;
    case (fn)
      FN_EVENT: begin
        last_hit = -1;
        for (int i = 0; i < listeners.size(); i++) begin
          if (listener_fires(listeners[i], ent.modifier, kc, ch)) last_hit = i;
        end
        if (last_hit < 0) begin
          owe(16'h0000, ST_NOMATCH, 1'b1);
        end else begin
          for (int i = 0; i <= last_hit; i++) begin
            if (listener_fires(listeners[i], ent.modifier, kc, ch))
              owe(listeners[i].client, ST_OK, i == last_hit);
          end
        end
      end
      FN_ADD: begin
        if (find_listener(ent) >= 0) begin
          owe(16'h0000, ST_EXISTS, 1'b1);
        end else if (listeners.size() >= DEPTH) begin
          owe(16'h0000, ST_FULL, 1'b1);
        end else begin
          listeners.push_back(ent);
          owe(16'h0000, ST_OK, 1'b1);
        end
      end
      FN_REMOVE: begin
        pos = find_listener(ent);
        if (pos < 0) begin
          owe(16'h0000, ST_NOTFOUND, 1'b1);
        end else begin
          listeners.delete(pos);
          owe(16'h0000, ST_OK, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (owed_replies.size() == 0) begin
        $display("%0t: unexpected result client %h status %0d last %0d",
                 $time, out_tdata, out_tuser, out_tlast);
        fail_count++;
      end else begin
        want = owed_replies.pop_front();
        if (out_tdata !== want.client || out_tuser !== want.status ||
            out_tlast !== want.last) begin
          $display({"%0t: mismatch expected client %h status %0d last %0d, ",
                    "got client %h status %0d last %0d"},
                   $time, want.client, want.status, want.last, out_tdata, out_tuser,
                   out_tlast);
          fail_count++;
        end
      end
    end
  end

  // Count cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready runs, stall bursts and the long hold-off
  // ---------------------------------------------------------------------------

  initial begin
    @(negedge clk);
    forever begin
      if (hold_off_cycles != 0) begin
        out_tready <= 1'b0;
        repeat (hold_off_cycles) @(negedge clk);
        hold_off_cycles = 0;
      end else if (sink_stalls && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offer one transaction, starting and ending just after a falling edge
  task automatic send_item(input logic [1:0] fn, input entry_t ent, input logic [7:0] kc,
                           input logic [7:0] ch);
    int gap;
    gap = (src_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {ch, kc, ent.modifier, ent.key, ent.flags, ent.client};
    do @(posedge clk); while (!in_tready);
    apply_to_table(fn, ent, kc, ch);
    @(negedge clk);
  endtask

  task automatic key_event(input logic [7:0] mod, input logic [7:0] kc, input logic [7:0] ch);
    entry_t e;
    e = '0;
    e.modifier = mod;
    send_item(FN_EVENT, e, kc, ch);
  endtask

  // Stop offering and wait until every owed result has come back
  task automatic wait_all_replies();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (owed_replies.size() != 0);
  endtask

  // Small pools make duplicates and event hits likely; the random branch covers all bits
  function automatic logic [7:0] pick_key();
    case ($urandom_range(0, 4))
      0: return 8'($urandom);
      1: return 8'h1C;
      2: return 8'h61;
      3: return 8'hE0;
      default: return 8'h05;
    endcase
  endfunction

  function automatic logic [7:0] pick_mod();
    case ($urandom_range(0, 4))
      0: return 8'($urandom);
      1: return 8'h00;
      2: return 8'h80;
      3: return 8'h04;
      default: return 8'h84;
    endcase
  endfunction

  function automatic entry_t new_listener();
    entry_t e;
    e.client   = $urandom_range(0, 1) ? 16'($urandom_range(1, 6)) : 16'($urandom);
    e.flags    = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
    e.key      = pick_key();
    e.modifier = pick_mod();
    return e;
  endfunction

  // Random mix; add and remove shares steer the table fill level
  task automatic run_mix(input int n, input int add_pct, input int rem_pct);
    int done;
    int roll;
    entry_t ent;
    entry_t x;
    logic [7:0] kc;
    logic [7:0] ch;
    done = 0;
    while (done < n) begin
      roll = $urandom_range(0, 99);
      ent  = new_listener();
      kc   = pick_key();
      ch   = pick_key();
      if (roll < add_pct) begin
        // occasionally re-add an existing listener
        if (listeners.size() != 0 && $urandom_range(0, 4) == 0)
          ent = listeners[$urandom_range(0, listeners.size() - 1)];
        send_item(FN_ADD, ent, kc, ch);
        done++;
      end else if (roll < add_pct + rem_pct) begin
        if (listeners.size() != 0 && $urandom_range(0, 3) != 0)
          ent = listeners[$urandom_range(0, listeners.size() - 1)];
        send_item(FN_REMOVE, ent, kc, ch);
        done++;
      end else if (roll < 98) begin
        ent.client = 16'($urandom);
        // most events are aimed at a stored listener
        if (listeners.size() != 0 && $urandom_range(0, 4) < 3) begin
          x = listeners[$urandom_range(0, listeners.size() - 1)];
          ent.modifier = x.modifier;
          if (x.flags[FL_KEYCODE]) kc = x.key;
          if (x.flags[FL_CHARACTER]) ch = x.key;
        end
        send_item(FN_EVENT, ent, kc, ch);
        done++;
      end else begin
        send_item(FN_SPARE, ent, kc, ch);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Each operation and every status but full on a small table, field extremes included
  task automatic test_single_listeners();
    entry_t a;
    entry_t b;
    entry_t z;
    a = '{modifier: 8'h00, key: 8'h1C, flags: F_PRESS | F_CODE, client: 16'h1234};
    b = '{modifier: 8'hFF, key: 8'hFF, flags: 8'hFF, client: 16'hFFFF};
    z = '0;
    key_event(8'h00, 8'h00, 8'h00);       // empty table: no match
    send_item(FN_ADD, a, 8'h00, 8'h00);
    send_item(FN_ADD, a, 8'h00, 8'h00);   // duplicate
    key_event(8'h00, 8'h1C, 8'h00);       // pressed, keycode hit
    key_event(8'h80, 8'h1C, 8'h00);       // break bit set, listener wants press only
    send_item(FN_ADD, b, 8'h00, 8'h00);
    key_event(8'hFF, 8'h00, 8'hFF);       // released, character hit
    send_item(FN_ADD, z, 8'h00, 8'h00);   // no flags: can never fire
    send_item(FN_REMOVE, a, 8'h00, 8'h00);
    send_item(FN_REMOVE, a, 8'h00, 8'h00); // already gone
    send_item(FN_SPARE, a, 8'hFF, 8'hFF);  // unused selector: no result
    wait_all_replies();
  endtask

  // Fill the table, refuse one more, scan a full table and close a gap
  task automatic test_table_full();
    entry_t e;
    int base;
    base = listeners.size();
    for (int i = 0; i < DEPTH - base; i++) begin
      e = '{modifier: 8'h04, key: 8'h61, flags: F_PRESS | F_CHAR, client: 16'(16'h0100 + i)};
      send_item(FN_ADD, e, 8'h00, 8'h00);
    end
    e = '{modifier: 8'h04, key: 8'h61, flags: F_PRESS | F_CHAR, client: 16'h01FF};
    send_item(FN_ADD, e, 8'h00, 8'h00);
    key_event(8'h04, 8'h00, 8'h61);
    e.client = 16'h0106;
    send_item(FN_REMOVE, e, 8'h00, 8'h00);
    key_event(8'h04, 8'h00, 8'h61);
    wait_all_replies();
  endtask

  task automatic test_fill_heavy();
    run_mix(110, 50, 15);
  endtask

  // Receiver holds off while the sender keeps offering; then the sender pauses
  task automatic test_backpressure();
    hold_off_cycles = HOLD_CYCLES;
    run_mix(60, 35, 25);
    wait_all_replies();
  endtask

  task automatic test_drain_heavy();
    run_mix(110, 20, 45);
    wait_all_replies();
    run_mix(80, 35, 30);
  endtask

  // Last stretch at full rate on both sides
  task automatic test_no_idle();
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    run_mix(100, 35, 30);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_single_listeners();
    test_table_full();
    test_fill_heavy();
    test_backpressure();
    test_drain_heavy();
    test_no_idle();

    wait_all_replies();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && owed_replies.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
